/* sv/sgw_pkg.sv */
// sgw_pkg: shared types and constants for the spiral grid walk generator
// no dependencies; imported by every module of the block
`default_nettype none

package sgw_pkg;

  localparam int DEF_MAX_DIM = 256;
  localparam int CFG_W       = 9;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int COORD_W     = 8;

  // register index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  typedef enum logic [1:0] {
    HEAD_EAST,
    HEAD_SOUTH,
    HEAD_WEST,
    HEAD_NORTH
  } heading_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } walk_state_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
    logic               done_res;
  } out_beat_t;

  // result handoff from the walk sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_hs_t;

endpackage

`default_nettype wire

/* sv/spiral_grid_walk_generator_top.sv */
// out_data is loaded from the walk's result register (beat_r) when the output register takes it;
// a walking next beat first steps through spiral positions, one per cycle, until one is in the grid
// only one beat is in flight at a time: in_stall stays high from acceptance until the result moves
// into the output register
// reset: synchronous active-low; grid registers to 1, no walk active, output empty
`default_nettype none

module spiral_grid_walk_generator_top
  import sgw_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire in_beat_t          in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output out_beat_t              out_data,
  input  wire logic              out_stall,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [DIM_W-1:0] rows_eff, cols_eff;
  logic             cfg_wr;
  res_hs_t          res;
  logic             res_take;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) begin
        rows_nxt = pwdata[CFG_W-1:0];
      end else begin
        cols_nxt = pwdata[CFG_W-1:0];
      end
    end
    prdata = (paddr[2] == REG_COLS) ? DATA_W'(cols_r) : DATA_W'(rows_r);
  end

  // zero counts as one, anything above the limit clamps to it
  always_comb begin
    if (rows_r == '0) begin
      rows_eff = DIM_W'(1);
    end else if (32'(rows_r) > 32'(MAX_DIM)) begin
      rows_eff = DIM_W'(MAX_DIM);
    end else begin
      rows_eff = DIM_W'(rows_r);
    end
    if (cols_r == '0) begin
      cols_eff = DIM_W'(1);
    end else if (32'(cols_r) > 32'(MAX_DIM)) begin
      cols_eff = DIM_W'(MAX_DIM);
    end else begin
      cols_eff = DIM_W'(cols_r);
    end
  end

  sgw_walk #(.MAX_DIM(MAX_DIM)) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .rows     (rows_eff),
    .cols     (cols_eff),
    .cfg_wr   (cfg_wr),
    .res      (res),
    .res_take (res_take)
  );

  // output register takes a new beat when empty or being drained
  always_comb begin
    res_take      = res.valid && (!out_valid_r || !out_stall);
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.beat;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= CFG_W'(1);
      cols_r      <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("walk accepted a beat but did not go busy");

  a_no_result_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !res.valid)
    else $error("walk offers a result while taking input");

  a_done_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.done_res) |->
      (out_data.row == '0 && out_data.col == '0 && !out_data.last))
    else $error("done beat carries a cell");

  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_valid && $past(res.beat) == out_data))
    else $error("result handoff lost");

endmodule

`default_nettype wire

/* sv/sgw_step_unit.sv */
// sgw_step_unit: one spiral step - moves the position, updates segment
// bookkeeping and checks the new position against the grid; uses sgw_pkg
`default_nettype none

module sgw_step_unit
  import sgw_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic signed [$clog2(4*MAX_DIM+6)+1:0] pos_row,
  input  wire logic signed [$clog2(4*MAX_DIM+6)+1:0] pos_col,
  input  wire heading_t                              heading,
  input  wire logic [$clog2(4*MAX_DIM+6)-1:0]        seg_len,
  input  wire logic [$clog2(4*MAX_DIM+6)-1:0]        seg_prog,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]          rows,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]          cols,
  output logic signed [$clog2(4*MAX_DIM+6)+1:0]      nxt_row,
  output logic signed [$clog2(4*MAX_DIM+6)+1:0]      nxt_col,
  output heading_t                                   nxt_heading,
  output logic [$clog2(4*MAX_DIM+6)-1:0]             nxt_len,
  output logic [$clog2(4*MAX_DIM+6)-1:0]             nxt_prog,
  output logic                                       in_grid,
  output logic                                       runaway
);

  localparam int SEG_LIMIT = 4*MAX_DIM + 4;
  localparam int SEG_W     = $clog2(SEG_LIMIT + 2);
  localparam int POS_W     = SEG_W + 2;

  logic [SEG_W-1:0] prog_inc;
  logic [POS_W-1:0] rows_ext;
  logic [POS_W-1:0] cols_ext;

  always_comb begin
    nxt_row = pos_row;
    nxt_col = pos_col;
    case (heading)
      HEAD_EAST:  nxt_col = pos_col + POS_W'(1);
      HEAD_SOUTH: nxt_row = pos_row + POS_W'(1);
      HEAD_WEST:  nxt_col = pos_col - POS_W'(1);
      HEAD_NORTH: nxt_row = pos_row - POS_W'(1);
      default:    nxt_row = pos_row;
    endcase

    prog_inc = seg_prog + SEG_W'(1);
    if (prog_inc >= seg_len) begin
      nxt_prog    = '0;
      nxt_heading = heading_t'(heading + 2'd1);
      // segment grows each time the walk turns back to east or west
      if (nxt_heading == HEAD_EAST || nxt_heading == HEAD_WEST) begin
        nxt_len = seg_len + SEG_W'(1);
      end else begin
        nxt_len = seg_len;
      end
    end else begin
      nxt_prog    = prog_inc;
      nxt_heading = heading;
      nxt_len     = seg_len;
    end

    rows_ext = POS_W'(rows);
    cols_ext = POS_W'(cols);
    in_grid  = !nxt_row[POS_W-1] && !nxt_col[POS_W-1] &&
               ($unsigned(nxt_row) < rows_ext) && ($unsigned(nxt_col) < cols_ext);
    runaway  = seg_len > SEG_W'(SEG_LIMIT);
  end

endmodule

`default_nettype wire

/* sv/sgw_walk.sv */
// sgw_walk: walk sequencer - holds the spiral state and drives the shared
// step unit one position per cycle; uses sgw_pkg and sgw_step_unit
`default_nettype none

module sgw_walk
  import sgw_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire in_beat_t                     in_data,
  output logic                              in_stall,
  input  wire logic [$clog2(MAX_DIM+1)-1:0] rows,
  input  wire logic [$clog2(MAX_DIM+1)-1:0] cols,
  input  wire logic                         cfg_wr,
  output res_hs_t                           res,
  input  wire logic                         res_take
);

  localparam int SEG_LIMIT = 4*MAX_DIM + 4;
  localparam int SEG_W     = $clog2(SEG_LIMIT + 2);
  localparam int POS_W     = SEG_W + 2;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int CNT_W     = $clog2(MAX_DIM*MAX_DIM + 1);

  walk_state_t              state_r, state_nxt;
  logic signed [POS_W-1:0]  row_r, row_nxt;
  logic signed [POS_W-1:0]  col_r, col_nxt;
  heading_t                 head_r, head_nxt;
  logic [SEG_W-1:0]         len_r, len_nxt;
  logic [SEG_W-1:0]         prog_r, prog_nxt;
  logic [CNT_W-1:0]         visited_r, visited_nxt;
  logic [CNT_W-1:0]         total_r, total_nxt;
  logic                     finished_r, finished_nxt;
  out_beat_t                beat_r, beat_nxt;

  logic signed [POS_W-1:0]  st_row, st_col;
  heading_t                 st_head;
  logic [SEG_W-1:0]         st_len, st_prog;
  logic                     st_in_grid, st_runaway;
  logic [COORD_W-1:0]       sr, sc;
  logic [CNT_W-1:0]         visited_inc;
  logic                     one_cell;
  logic                     fin;

  sgw_step_unit #(.MAX_DIM(MAX_DIM)) u_step (
    .pos_row     (row_r),
    .pos_col     (col_r),
    .heading     (head_r),
    .seg_len     (len_r),
    .seg_prog    (prog_r),
    .rows        (rows),
    .cols        (cols),
    .nxt_row     (st_row),
    .nxt_col     (st_col),
    .nxt_heading (st_head),
    .nxt_len     (st_len),
    .nxt_prog    (st_prog),
    .in_grid     (st_in_grid),
    .runaway     (st_runaway)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      row_r      <= '0;
      col_r      <= '0;
      head_r     <= HEAD_EAST;
      len_r      <= SEG_W'(1);
      prog_r     <= '0;
      visited_r  <= '0;
      total_r    <= '0;
      finished_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      head_r     <= head_nxt;
      len_r      <= len_nxt;
      prog_r     <= prog_nxt;
      visited_r  <= visited_nxt;
      total_r    <= total_nxt;
      finished_r <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    head_nxt     = head_r;
    len_nxt      = len_r;
    prog_nxt     = prog_r;
    visited_nxt  = visited_r;
    total_nxt    = total_r;
    finished_nxt = finished_r;
    beat_nxt     = beat_r;

    in_stall  = (state_r != ST_IDLE);
    res.valid = (state_r == ST_EMIT);
    res.beat  = beat_r;

    // start cell saturates to the last row or column
    sr = (32'(in_data.start_row) >= 32'(rows)) ? COORD_W'(rows - DIM_W'(1))
                                                : in_data.start_row;
    sc = (32'(in_data.start_col) >= 32'(cols)) ? COORD_W'(cols - DIM_W'(1))
                                                : in_data.start_col;
    one_cell    = (rows == DIM_W'(1)) && (cols == DIM_W'(1));
    visited_inc = visited_r + CNT_W'(1);
    fin         = (visited_inc >= total_r);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_START) begin
            row_nxt      = POS_W'(sr);
            col_nxt      = POS_W'(sc);
            head_nxt     = HEAD_EAST;
            len_nxt      = SEG_W'(1);
            prog_nxt     = '0;
            visited_nxt  = CNT_W'(1);
            total_nxt    = CNT_W'(rows) * CNT_W'(cols);
            finished_nxt = one_cell;
            beat_nxt     = '{row: sr, col: sc, last: one_cell, done_res: 1'b0};
            state_nxt    = ST_EMIT;
          end else if (finished_r) begin
            beat_nxt  = '{row: '0, col: '0, last: 1'b0, done_res: 1'b1};
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (st_runaway) begin
          finished_nxt = 1'b1;
          beat_nxt     = '{row: '0, col: '0, last: 1'b0, done_res: 1'b1};
          state_nxt    = ST_EMIT;
        end else begin
          row_nxt  = st_row;
          col_nxt  = st_col;
          head_nxt = st_head;
          len_nxt  = st_len;
          prog_nxt = st_prog;
          if (st_in_grid) begin
            visited_nxt  = visited_inc;
            finished_nxt = fin;
            beat_nxt     = '{row: COORD_W'($unsigned(st_row)),
                             col: COORD_W'($unsigned(st_col)),
                             last: fin, done_res: 1'b0};
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // any register write ends the active walk
    if (cfg_wr) begin
      finished_nxt = 1'b1;
    end
  end

endmodule

`default_nettype wire
